/* rtl/core/tcw_pkg.sv */
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS = 25;
   localparam int CELLS = COLUMNS * ROWS;
   localparam int TAB_STEP = 4;

   localparam int COL_W = 7;
   localparam int ROW_W = 5;
   localparam int ADDR_W = 11;
   localparam int DATA_W = 16;

   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LINE_FEED = 8'h0A;
   localparam logic [7:0] CHAR_RETURN = 8'h0D;
   localparam logic [7:0] CHAR_BLANK = 8'h20;
   localparam logic [7:0] ATTR_RESET = 8'h0F;

   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W:0] CELL_LIMIT = (ADDR_W + 1)'(CELLS);

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_BLANK,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             write_glyph;
      logic             scroll;
   } put_plan_type;

endpackage

/* rtl/core/tcw_cursor.sv */
module tcw_cursor
   import tcw_pkg::*;
(
   input  logic [COL_W-1:0] col,
   input  logic [ROW_W-1:0] row,
   input  logic [7:0]       char_code,
   output put_plan_type     plan
);

   logic [COL_W:0] col_wide;
   logic [COL_W:0] col_tab;
   logic [COL_W:0] col_next;
   logic [ROW_W:0] row_next;
   logic           last_row;
   logic           wrap;

   assign col_wide = {1'b0, col};
   assign col_tab  = col_wide + (COL_W + 1)'(TAB_STEP);
   assign col_next = col_wide + (COL_W + 1)'(1);
   assign row_next = {1'b0, row} + (ROW_W + 1)'(1);
   assign last_row = (row_next >= (ROW_W + 1)'(ROWS));

   always_comb begin
      plan.col         = col;
      plan.row         = row;
      plan.write_glyph = 1'b0;
      plan.scroll      = 1'b0;
      wrap             = 1'b0;
      if (char_code == CHAR_BACKSPACE && col != '0) begin
         plan.col = col - COL_W'(1);
      end else if (char_code == CHAR_TAB &&
                   col_wide <= (COL_W + 1)'(COLUMNS - TAB_STEP)) begin
         plan.col = col_tab[COL_W-1:0];
         wrap     = (col_tab >= (COL_W + 1)'(COLUMNS));
      end else if (char_code == CHAR_RETURN) begin
         plan.col = '0;
      end else if (char_code == CHAR_LINE_FEED) begin
         wrap = 1'b1;
      end else begin
         plan.write_glyph = 1'b1;
         plan.col         = col_next[COL_W-1:0];
         wrap             = (col_next >= (COL_W + 1)'(COLUMNS));
      end
      // Wrapping past the bottom row keeps the cursor there and scrolls the store.
      if (wrap) begin
         plan.col = '0;
         if (last_row) begin
            plan.scroll = 1'b1;
            plan.row    = ROW_W'(ROWS - 1);
         end else begin
            plan.row = row_next[ROW_W-1:0];
         end
      end
   end

endmodule

/* rtl/core/text_console_writer_core.sv */
// Text console of 80 columns by 25 rows with a 2000-cell screen store.
// The request channel (req_valid/req_ready) carries an operation: put a
// character, clear the screen, or read one cell. Every request yields exactly
// one transfer on the response channel (rsp_valid/rsp_ready) that reports the
// cell read (zero for other operations) and the cursor after the operation.
// csr_valid/csr_ready writes the attribute byte; it is always ready and should
// only be written while no request is outstanding.
// A put without scroll, a read outside the store and the unused op code
// answer at the accepting edge. A read passes through the ST_READ state for
// the registered memory port. A scroll copies 1920 cells through one read and
// one write port, then blanks 80 cells. A clear writes all 2000 cells, one per
// cycle. One request is in flight at a time; the response register lets a new
// request enter in the cycle the old result is taken.
// When the receiver stalls, the response holds and req_ready stays low.
// Synchronous reset homes the cursor and sets the attribute to 0x0F; the
// store is not cleared, so software issues a clear before any read.
module text_console_writer_core
   import tcw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [7:0]        req_char_code,
   input  logic [ADDR_W-1:0] req_cell_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_cell_data,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [ADDR_W-1:0] rsp_cursor_addr,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_text_attribute
);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [7:0]        attr_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;

   logic [DATA_W-1:0] mem [CELLS];
   logic [DATA_W-1:0] mem_q;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [ADDR_W-1:0] mem_ra;
   logic [DATA_W-1:0] mem_wd;

   logic              accept;
   logic              idx_valid;
   logic              rsp_load;
   logic [DATA_W-1:0] rsp_data_in;
   logic [ADDR_W-1:0] cur_addr;
   logic [DATA_W-1:0] blank_cell;
   put_plan_type      plan;

   tcw_cursor u_cursor (
      .col       (col_ff),
      .row       (row_ff),
      .char_code (req_char_code),
      .plan      (plan)
   );

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign idx_valid  = ({1'b0, req_cell_index} < CELL_LIMIT);
   assign cur_addr   = ADDR_W'(row_ff) * ROW_STRIDE + ADDR_W'(col_ff);
   assign blank_cell = {attr_ff, CHAR_BLANK};
   assign csr_ready  = 1'b1;

   // Next state, cursor and sweep counter.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_PUT: begin
                     col_in = plan.col;
                     row_in = plan.row;
                     if (plan.scroll) begin
                        state_in = ST_SCROLL;
                        cnt_in   = '0;
                     end
                  end
                  OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     state_in = ST_CLEAR;
                     cnt_in   = '0;
                  end
                  OP_READ: begin
                     if (idx_valid) begin
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_SCROLL: begin
            // The bottom row is blanked from the same counter value onward.
            if (cnt_ff == SCROLL_LAST) begin
               state_in = ST_BLANK;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_BLANK, ST_CLEAR: begin
            if (cnt_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory ports and response loading.
   always_comb begin
      mem_we      = 1'b0;
      mem_wa      = cur_addr;
      mem_wd      = blank_cell;
      mem_ra      = idx_valid ? req_cell_index : '0;
      rsp_load    = 1'b0;
      rsp_data_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_PUT: begin
                     mem_we   = plan.write_glyph;
                     mem_wd   = {attr_ff, req_char_code};
                     rsp_load = !plan.scroll;
                  end
                  OP_CLEAR: rsp_load = 1'b0;
                  OP_READ: rsp_load = !idx_valid;
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            rsp_load    = 1'b1;
            rsp_data_in = mem_q;
         end
         ST_SCROLL: begin
            // Each cell is read one row below and written back in the following cycle.
            mem_ra = (cnt_ff < SCROLL_LAST) ? cnt_ff + ROW_STRIDE : '0;
            mem_we = (cnt_ff != '0);
            mem_wa = cnt_ff - ADDR_W'(1);
            mem_wd = mem_q;
         end
         ST_BLANK, ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_wa   = cnt_ff;
            rsp_load = (cnt_ff == LAST_CELL);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      mem_q <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (csr_valid && csr_ready) begin
            attr_ff <= csr_text_attribute;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_col_ff  <= col_in;
         rsp_row_ff  <= row_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_data   = rsp_data_ff;
   assign rsp_cursor_col  = rsp_col_ff;
   assign rsp_cursor_row  = rsp_row_ff;
   assign rsp_cursor_addr = ADDR_W'(rsp_row_ff) * ROW_STRIDE + ADDR_W'(rsp_col_ff);

`ifndef SYNTHESIS
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while a sweep is running");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff < COL_W'(COLUMNS)) && (row_ff < ROW_W'(ROWS)))
      else $error("cursor outside the screen");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ({1'b0, mem_wa} < CELL_LIMIT))
      else $error("store write beyond the last cell");

   a_read_answer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("cell read did not produce a response");
`endif

endmodule

/* test/text_console_writer_core_tb.sv */
module text_console_writer_core_tb
   import tcw_pkg::*;
();

   typedef struct packed {
      logic [DATA_W-1:0] cell_data;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [ADDR_W-1:0] addr;
   } console_reply_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_op;
   logic [7:0]        req_char_code;
   logic [ADDR_W-1:0] req_cell_index;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [DATA_W-1:0] rsp_cell_data;
   logic [COL_W-1:0]  rsp_cursor_col;
   logic [ROW_W-1:0]  rsp_cursor_row;
   logic [ADDR_W-1:0] rsp_cursor_addr;
   logic              csr_valid;
   logic              csr_ready;
   logic [7:0]        csr_text_attribute;

   // Shadow copy of the console: screen cells, cursor and attribute byte.
   logic [DATA_W-1:0] screen_copy [CELLS];
   int                cur_col;
   int                cur_row;
   logic [7:0]        attr_byte;

   console_reply_type pending_replies [$];
   int                error_count = 0;
   bit                no_gaps = 1'b0;

   text_console_writer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_char_code      (req_char_code),
      .req_cell_index     (req_cell_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cell_data      (rsp_cell_data),
      .rsp_cursor_col     (rsp_cursor_col),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cursor_addr    (rsp_cursor_addr),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void advance_line();
      int i;
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         for (i = 0; i < CELLS - COLUMNS; i++) screen_copy[i] = screen_copy[i + COLUMNS];
         for (i = CELLS - COLUMNS; i < CELLS; i++) screen_copy[i] = {attr_byte, CHAR_BLANK};
         cur_row = ROWS - 1;
      end
   endfunction

   function automatic console_reply_type console_step(op_type op, logic [7:0] ch,
                                                      logic [ADDR_W-1:0] idx);
      console_reply_type r;
      int i;
      r.cell_data = '0;
      case (op)
         OP_PUT: begin
            if (ch == CHAR_BACKSPACE && cur_col != 0) begin
               cur_col--;
            end else if (ch == CHAR_TAB && cur_col <= COLUMNS - TAB_STEP) begin
               cur_col += TAB_STEP;
               if (cur_col >= COLUMNS) advance_line();
            end else if (ch == CHAR_RETURN) begin
               cur_col = 0;
            end else if (ch == CHAR_LINE_FEED) begin
               advance_line();
            end else begin
               // Any other code, including the control codes that fall through, is a glyph.
               screen_copy[cur_row * COLUMNS + cur_col] = {attr_byte, ch};
               cur_col++;
               if (cur_col >= COLUMNS) advance_line();
            end
         end
         OP_CLEAR: begin
            for (i = 0; i < CELLS; i++) screen_copy[i] = {attr_byte, CHAR_BLANK};
            cur_col = 0;
            cur_row = 0;
         end
         OP_READ: begin
            if (idx < CELLS) r.cell_data = screen_copy[idx];
         end
         default: ;
      endcase
      r.col = COL_W'(cur_col);
      r.row = ROW_W'(cur_row);
      r.addr = ADDR_W'(cur_row * COLUMNS + cur_col);
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] junk_index();
      return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
   endfunction

   function automatic logic [7:0] junk_char();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_glyph();
      logic [7:0] c;
      do c = junk_char();
      while (c == CHAR_BACKSPACE || c == CHAR_TAB || c == CHAR_LINE_FEED || c == CHAR_RETURN);
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      error_count++;
      if (error_count <= 100) $display("MISMATCH %s: got %h, expected %h", what, got, want);
   endtask

   // Valid is left high after a transfer so that back-to-back requests need no gap.
   task automatic issue_request(op_type op, logic [7:0] ch, logic [ADDR_W-1:0] idx);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_char_code <= ch;
      req_cell_index <= idx;
      do @(posedge clock);
      while (!req_ready);
      pending_replies.push_back(console_step(op, ch, idx));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_attr(logic [7:0] value);
      csr_valid <= 1'b1;
      csr_text_attribute <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      attr_byte = value;
   endtask

   task automatic read_cell(int where);
      issue_request(OP_READ, junk_char(), ADDR_W'(where));
   endtask

   task automatic put_char(logic [7:0] ch);
      issue_request(OP_PUT, ch, junk_index());
   endtask

   task automatic test_basic_ops();
      issue_request(OP_CLEAR, junk_char(), junk_index());
      read_cell(0);
      read_cell(CELLS - 1);
      read_cell(CELLS);
      read_cell((1 << ADDR_W) - 1);
      issue_request(OP_NOP, 8'hFF, '1);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(CHAR_BACKSPACE);
      read_cell(1);
      put_char(CHAR_RETURN);
      // Backspace at column zero is stored as a glyph.
      put_char(CHAR_BACKSPACE);
      read_cell(0);
      put_char(CHAR_TAB);
      put_char(CHAR_LINE_FEED);
      put_char(8'h41);
      read_cell(COLUMNS);
      issue_request(OP_NOP, 8'h00, '0);
      wait_drained();
   endtask

   task automatic test_tab_margin();
      int row_base;
      put_char(CHAR_RETURN);
      while (cur_col < COLUMNS - TAB_STEP) put_char(CHAR_TAB);
      // A tab from the last tab stop lands on the column count and wraps.
      put_char(CHAR_TAB);
      row_base = cur_row * COLUMNS;
      while (cur_col < COLUMNS - TAB_STEP) put_char(CHAR_TAB);
      put_char(pick_glyph());
      // Tabs beyond the last tab stop are written as glyphs until the line wraps.
      while (cur_col != 0) put_char(CHAR_TAB);
      read_cell(row_base + COLUMNS - 3);
      read_cell(row_base + COLUMNS - 1);
      wait_drained();
   endtask

   task automatic test_last_row();
      while (cur_row < ROWS - 1) put_char(CHAR_LINE_FEED);
      repeat (6) put_char(pick_glyph());
      put_char(CHAR_LINE_FEED);
      read_cell((ROWS - 2) * COLUMNS + 2);
      read_cell((ROWS - 1) * COLUMNS + 2);
      // A full row of glyphs on the last row wraps and scrolls.
      repeat (COLUMNS) put_char(pick_glyph());
      read_cell((ROWS - 2) * COLUMNS);
      read_cell(CELLS - 1);
      put_char(CHAR_LINE_FEED);
      put_char(CHAR_LINE_FEED);
      read_cell((ROWS - 4) * COLUMNS + 5);
      wait_drained();
   endtask

   task automatic send_random_item();
      int r;
      int k;
      int where;
      r = $urandom_range(0, 99);
      if (r < 1) begin
         issue_request(OP_CLEAR, junk_char(), junk_index());
      end else if (r < 3) begin
         issue_request(OP_NOP, junk_char(), junk_index());
      end else if (r < 16) begin
         k = $urandom_range(0, 9);
         if (k == 0) where = CELLS + $urandom_range(0, (1 << ADDR_W) - 1 - CELLS);
         else if (k == 1) where = junk_index();
         else if (k < 6) where = cur_row * COLUMNS + cur_col - $urandom_range(0, COLUMNS);
         else where = $urandom_range(0, CELLS - 1);
         if (where < 0) where = 0;
         read_cell(where);
      end else begin
         k = $urandom_range(0, 99);
         if (k < 4) put_char(CHAR_LINE_FEED);
         else if (k < 9) put_char(CHAR_RETURN);
         else if (k < 17) put_char(CHAR_BACKSPACE);
         else if (k < 27) put_char(CHAR_TAB);
         else put_char(junk_char());
      end
   endtask

   task automatic test_random_traffic(logic [7:0] attr, bit quiet, int count);
      wait_drained();
      write_attr(attr);
      no_gaps = quiet;
      repeat (count) send_random_item();
      wait_drained();
      no_gaps = 1'b0;
   endtask

   always @(posedge clock) begin : check_replies
      console_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected response transfer", rsp_cell_data, '0);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_cell_data !== want.cell_data)
               report_mismatch("cell_data", rsp_cell_data, want.cell_data);
            if (rsp_cursor_col !== want.col)
               report_mismatch("cursor_col", DATA_W'(rsp_cursor_col), DATA_W'(want.col));
            if (rsp_cursor_row !== want.row)
               report_mismatch("cursor_row", DATA_W'(rsp_cursor_row), DATA_W'(want.row));
            if (rsp_cursor_addr !== want.addr)
               report_mismatch("cursor_addr", DATA_W'(rsp_cursor_addr), DATA_W'(want.addr));
         end
      end
   end

   // After each transfer the receiver may drop rsp_ready for a random stall, unless no_gaps is set.
   initial begin : response_sink
      int gap;
      rsp_ready <= 1'b1;
      wait (reset == 1'b0);
      forever begin
         do @(posedge clock);
         while (!(rsp_valid && rsp_ready));
         gap = no_gaps ? 0 : $urandom_range(0, 14);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int i;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= OP_NOP;
      req_char_code <= '0;
      req_cell_index <= '0;
      csr_valid <= 1'b0;
      csr_text_attribute <= ATTR_RESET;
      for (i = 0; i < CELLS; i++) screen_copy[i] = '0;
      cur_col = 0;
      cur_row = 0;
      attr_byte = ATTR_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_tab_margin();
      test_last_row();
      test_random_traffic(8'h00, 1'b0, 300);
      test_random_traffic(8'hFF, 1'b1, 200);
      test_tab_margin();
      test_random_traffic(junk_char(), 1'b0, 300);
      test_random_traffic(junk_char(), 1'b0, 300);
      test_last_row();

      wait_drained();
      repeat (2100) @(posedge clock);
      if (error_count == 0 && pending_replies.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #150000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
